FILE: rtl/sialu_pkg.sv
// Shared types and constants for the signed ALU with serial multiply and divide.
package sialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic out_write;
    } dp_ctrl_t;

endpackage

FILE: rtl/sialu_ctrl.sv
// Sequencer: handshakes, bit counter and output valid for the serial ALU.
module sialu_ctrl
    import sialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cmd_t     cmd,
    input  logic     b_zero,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_ctrl_t ctl
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;
    logic             needs_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free      = !out_valid_reg || out_ready;
        in_ready      = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free);
        accept        = in_valid && in_ready;
        // multiply and a nonzero divide iterate; everything else finishes at load
        needs_run     = (cmd == CMD_MUL) || ((cmd == CMD_DIV) && !b_zero);
        ctl.load      = accept;
        ctl.step      = (state_reg == ST_RUN);
        ctl.out_write = (state_reg == ST_FIN) && out_free;

        state_next = state_reg;
        count_next = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_run ? ST_RUN : ST_FIN;
                end
            end
            ST_RUN:
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (accept)
                    begin
                        state_next = needs_run ? ST_RUN : ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            count_next = CNT_W'(DATA_WIDTH - 1);
        end

        if (ctl.out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !in_ready)
        else $error("input taken while an item iterates");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (count_reg == '0)) |=> (state_reg == ST_FIN))
        else $error("iteration did not end after the last bit");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && needs_run) |=> ((state_reg == ST_RUN) && (count_reg == CNT_W'(DATA_WIDTH - 1))))
        else $error("iteration started with a wrong bit count");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_write |=> out_valid_reg)
        else $error("written result not presented");

endmodule

FILE: rtl/sialu_dpath.sv
// Datapath: operand registers, shift-add multiply and restoring divide, one bit a cycle.
module sialu_dpath
    import sialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  dp_ctrl_t              ctl,
    input  cmd_t                  cmd,
    input  logic [DATA_WIDTH-1:0] opa,
    input  logic [DATA_WIDTH-1:0] opb,
    output logic                  b_zero,
    output logic [DATA_WIDTH-1:0] result,
    output logic                  dbz
);

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MAX = {1'b1, {(W-2){1'b0}}, 1'b1};

    cmd_t         cmd_reg, cmd_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] aux_reg, aux_next;
    logic [W-1:0] opb_reg, opb_next;
    logic [W-1:0] rem_reg, rem_next;
    logic         neg_reg, neg_next;
    logic         dbz_reg, dbz_next;
    logic [W-1:0] res_reg, res_next;
    logic         dbz_out_reg, dbz_out_next;

    logic         a_neg;
    logic         b_neg;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W:0]   rem_sh;
    logic [W+1:0] diff;
    logic         fits;

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        acc_reg     <= acc_next;
        aux_reg     <= aux_next;
        opb_reg     <= opb_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        dbz_reg     <= dbz_next;
        res_reg     <= res_next;
        dbz_out_reg <= dbz_out_next;
    end

    always_comb
    begin
        a_neg  = opa[W-1];
        b_neg  = opb[W-1];
        mag_a  = a_neg ? (~opa + 1'b1) : opa;
        mag_b  = b_neg ? (~opb + 1'b1) : opb;
        b_zero = (opb == '0);

        // bring down the next dividend bit and try the divisor
        rem_sh = {rem_reg, aux_reg[W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, opb_reg};
        fits   = !diff[W+1];

        cmd_next     = cmd_reg;
        acc_next     = acc_reg;
        aux_next     = aux_reg;
        opb_next     = opb_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        dbz_next     = dbz_reg;
        res_next     = res_reg;
        dbz_out_next = dbz_out_reg;

        if (ctl.out_write)
        begin
            dbz_out_next = dbz_reg;
            if ((cmd_reg == CMD_DIV) && !dbz_reg)
            begin
                if (neg_reg)
                begin
                    res_next = ~acc_reg + 1'b1;
                end
                else if (acc_reg[W-1])
                begin
                    // most negative over minus one: saturate
                    res_next = MAX_POS;
                end
                else
                begin
                    res_next = acc_reg;
                end
            end
            else
            begin
                res_next = acc_reg;
            end
        end

        if (ctl.load)
        begin
            cmd_next = cmd;
            dbz_next = 1'b0;
            neg_next = a_neg ^ b_neg;
            rem_next = '0;
            aux_next = opa;
            opb_next = opb;
            case (cmd)
                CMD_ADD:
                begin
                    acc_next = opa + opb;
                end
                CMD_SUB:
                begin
                    acc_next = opa - opb;
                end
                CMD_MUL:
                begin
                    acc_next = '0;
                end
                CMD_DIV:
                begin
                    aux_next = mag_a;
                    opb_next = mag_b;
                    if (b_zero)
                    begin
                        dbz_next = 1'b1;
                        acc_next = a_neg ? NEG_MAX : MAX_POS;
                    end
                    else
                    begin
                        acc_next = '0;
                    end
                end
                default:
                begin
                    acc_next = '0;
                end
            endcase
        end
        else if (ctl.step)
        begin
            aux_next = {aux_reg[W-2:0], 1'b0};
            case (cmd_reg)
                CMD_MUL:
                begin
                    acc_next = acc_reg + (opb_reg[0] ? aux_reg : '0);
                    opb_next = {1'b0, opb_reg[W-1:1]};
                end
                CMD_DIV:
                begin
                    acc_next = {acc_reg[W-2:0], fits};
                    rem_next = fits ? diff[W-1:0] : rem_sh[W-1:0];
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    assign result = res_reg;
    assign dbz    = dbz_out_reg;

endmodule

FILE: rtl/signed_int32_alu_mul_div_unit.sv
// Add and subtract go from accept through the FIN state into the result register;
// multiply and divide iterate in RUN first, one quotient or product bit per cycle, then FIN.
// Add and subtract take one item per cycle while out_ready holds; multiply and divide take
// no new item until the iteration ends, set by the single shift-add / restoring-subtract unit.
// A zero divisor skips the iteration and completes like an add.
// Reset (rst_n low, asynchronous) idles the sequencer and drops out_valid; data is not cleared.
module signed_int32_alu_mul_div_unit
    import sialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   command,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] result_value,
    output logic                         divide_by_zero
);

    dp_ctrl_t              ctl;
    cmd_t                  cmd;
    logic                  b_zero;
    logic [DATA_WIDTH-1:0] result;

    assign cmd = cmd_t'(command);

    sialu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .b_zero    (b_zero),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    sialu_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk    (clk),
        .ctl    (ctl),
        .cmd    (cmd),
        .opa    (operand_a),
        .opb    (operand_b),
        .b_zero (b_zero),
        .result (result),
        .dbz    (divide_by_zero)
    );

    assign result_value = $signed(result);

endmodule
